// ===== rtl/tsdc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsdc_pkg
// Shared types, constants and the arctangent table of the track segment
// distance classifier.
// ----------------------------------------------------------------------------
package tsdc_pkg;

    localparam int CW = 34;
    typedef logic signed [CW-1:0] cord_t;

    localparam int LAT_W  = 31;
    localparam int LON_W  = 32;
    localparam int DIST_W = 25;
    localparam int MAG_W  = 31;
    localparam int SQ_W   = 31;
    localparam int RAD_W  = 61;

    localparam logic signed [35:0] TURN_U    = 36'sd7200000000;
    localparam logic signed [35:0] HALF_U    = 36'sd3600000000;
    localparam logic signed [35:0] QUARTER_U = 36'sd1800000000;

    localparam logic [23:0] RAD_SCALE = 24'd15720528;
    localparam cord_t       INV_GAIN  = 34'sd652032874;
    localparam logic [22:0] RADIUS_M  = 23'd6371000;
    localparam logic [DIST_W-1:0] DIST_CAP = 25'd20016000;
    localparam logic [SQ_W-1:0]   Q30_ONE  = 31'd1073741824;

    localparam logic [DIST_W-1:0] MAX_DIST_RESET = 25'd1000;

    localparam logic ADDR_MAX_DIST   = 1'b0;
    localparam logic ADDR_COLOR_MODE = 1'b1;

    localparam logic [DIST_W-1:0] BAND_0 = 25'd41;
    localparam logic [DIST_W-1:0] BAND_1 = 25'd83;
    localparam logic [DIST_W-1:0] BAND_2 = 25'd166;
    localparam logic [DIST_W-1:0] BAND_3 = 25'd250;
    localparam logic [DIST_W-1:0] BAND_4 = 25'd416;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } colour_t;

    localparam colour_t COL_NONE   = '{8'd0,   8'd0,   8'd0,   8'd0};
    localparam colour_t COL_WHITE  = '{8'd255, 8'd255, 8'd255, 8'd255};
    localparam colour_t COL_BAND_0 = '{8'd0,   8'd0,   8'd139, 8'd255};
    localparam colour_t COL_BAND_1 = '{8'd173, 8'd216, 8'd230, 8'd255};
    localparam colour_t COL_BAND_2 = '{8'd0,   8'd255, 8'd0,   8'd255};
    localparam colour_t COL_BAND_3 = '{8'd255, 8'd255, 8'd0,   8'd255};
    localparam colour_t COL_BAND_4 = '{8'd255, 8'd165, 8'd0,   8'd255};
    localparam colour_t COL_FAR    = '{8'd150, 8'd0,   8'd0,   8'd150};

    function automatic cord_t atan_entry(input int i);
        cord_t v;
        v = '0;
        unique case (i)
            0: v = 34'sd843314857;
            1: v = 34'sd497837829;
            2: v = 34'sd263043837;
            3: v = 34'sd133525159;
            4: v = 34'sd67021687;
            5: v = 34'sd33543516;
            6: v = 34'sd16775851;
            7: v = 34'sd8388437;
            8: v = 34'sd4194283;
            9: v = 34'sd2097149;
            default: begin
                if (i <= 30) begin
                    v = 34'sd1 <<< (30 - i);
                end else begin
                    v = '0;
                end
            end
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/tsdc_cordic.sv =====
// ----------------------------------------------------------------------------
// tsdc_cordic
// Pipelined CORDIC, one micro-rotation per register stage, in rotation or
// vectoring mode.
// ----------------------------------------------------------------------------
module tsdc_cordic import tsdc_pkg::*; #(
    parameter int STAGES    = 24,
    parameter bit VECTORING = 1'b0
) (
    input  logic  aclk,
    input  logic  en,
    input  cord_t x_in,
    input  cord_t y_in,
    input  cord_t z_in,
    output cord_t x_out,
    output cord_t y_out,
    output cord_t z_out
);

    cord_t x_reg [STAGES];
    cord_t y_reg [STAGES];
    cord_t z_reg [STAGES];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        cord_t xi, yi, zi, dx, dy;
        logic  pos;

        if (i == 0) begin : g_first
            assign xi = x_in;
            assign yi = y_in;
            assign zi = z_in;
        end else begin : g_next
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
        end

        assign dx  = yi >>> i;
        assign dy  = xi >>> i;
        assign pos = VECTORING ? (yi <= 0) : (zi >= 0);

        always_ff @(posedge aclk) begin
            if (en) begin
                if (pos) begin
                    x_reg[i] <= xi - dx;
                    y_reg[i] <= yi + dy;
                    z_reg[i] <= zi - atan_entry(i);
                end else begin
                    x_reg[i] <= xi + dx;
                    y_reg[i] <= yi - dy;
                    z_reg[i] <= zi + atan_entry(i);
                end
            end
        end
    end

    assign x_out = x_reg[STAGES-1];
    assign y_out = y_reg[STAGES-1];
    assign z_out = z_reg[STAGES-1];

endmodule

// ===== rtl/tsdc_isqrt.sv =====
// ----------------------------------------------------------------------------
// tsdc_isqrt
// Pipelined floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module tsdc_isqrt import tsdc_pkg::*; (
    input  logic             aclk,
    input  logic             en,
    input  logic [RAD_W-1:0] v_in,
    output logic [SQ_W-1:0]  root_out
);

    localparam int RW = 2 * SQ_W;

    logic [RW-1:0]   rem_reg  [SQ_W];
    logic [SQ_W-1:0] root_reg [SQ_W];

    for (genvar j = 0; j < SQ_W; j++) begin : g_stage
        localparam int K = SQ_W - 1 - j;
        logic [RW-1:0]   rem_in, trial;
        logic [SQ_W-1:0] root_in;

        if (j == 0) begin : g_first
            assign rem_in  = RW'(v_in);
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
        end

        assign trial = (RW'(root_in) << (K + 1)) + (RW'(1) << (2 * K));

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_in >= trial) begin
                    rem_reg[j]  <= rem_in - trial;
                    root_reg[j] <= root_in | (SQ_W'(1) << K);
                end else begin
                    rem_reg[j]  <= rem_in;
                    root_reg[j] <= root_in;
                end
            end
        end
    end

    assign root_out = root_reg[SQ_W-1];

endmodule

// ===== rtl/track_segment_distance_classifier.sv =====
// ----------------------------------------------------------------------------
// track_segment_distance_classifier
// Haversine distance between consecutive track points with threshold and
// colour banding, fully pipelined.
// ----------------------------------------------------------------------------
// One point is taken every cycle while the result side drains. The pipeline
// depth is set by the rotation CORDICs, the two square-root pipelines and
// the vectoring CORDIC. aresetn is synchronous and active low; it clears the
// pipeline valid bits, the stored point and the registers to their defaults.
// ----------------------------------------------------------------------------
module track_segment_distance_classifier import tsdc_pkg::*; #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // latitude[30:0], longitude[62:31], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // distance_m[24:0], segment_drawn[25],
                                   // red[33:26], green[41:34], blue[49:42],
                                   // alpha[57:50], zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int N   = CORDIC_STAGES;
    localparam int LAT = 42 + 2 * N;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Configuration registers.
    logic [DIST_W-1:0] max_dist_reg;
    logic              color_mode_reg;

    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[2])
            ADDR_MAX_DIST:   prdata = 32'(max_dist_reg);
            ADDR_COLOR_MODE: prdata = 32'(color_mode_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_dist_reg   <= MAX_DIST_RESET;
            color_mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                ADDR_MAX_DIST:   max_dist_reg   <= pwdata[DIST_W-1:0];
                ADDR_COLOR_MODE: color_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Valid and previous-point flags travel alongside the data.
    logic vld_reg [LAT];
    logic hp_reg  [LAT];
    logic have_prev_reg;
    logic signed [LAT_W-1:0] prev_lat_reg;
    logic signed [LON_W-1:0] prev_lon_reg;
    logic signed [LAT_W-1:0] lat_in;
    logic signed [LON_W-1:0] lon_in;

    assign lat_in = s_tdata[LAT_W-1:0];
    assign lon_in = s_tdata[LAT_W+LON_W-1:LAT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LAT; k++) begin
                vld_reg[k] <= 1'b0;
                hp_reg[k]  <= 1'b0;
            end
            have_prev_reg <= 1'b0;
            prev_lat_reg  <= '0;
            prev_lon_reg  <= '0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            hp_reg[0]  <= have_prev_reg;
            for (int k = 1; k < LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
                hp_reg[k]  <= hp_reg[k-1];
            end
            if (s_tvalid) begin
                have_prev_reg <= 1'b1;
                prev_lat_reg  <= lat_in;
                prev_lon_reg  <= lon_in;
            end
        end
    end

    // Stage 1: half-angle differences and doubled latitudes in 5e-8 degree.
    cord_t u_reg [4];
    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg[0] <= CW'(lat_in) - CW'(prev_lat_reg);
            u_reg[1] <= CW'(lon_in) - CW'(prev_lon_reg);
            u_reg[2] <= CW'(prev_lat_reg) <<< 1;
            u_reg[3] <= CW'(lat_in) <<< 1;
        end
    end

    // Stages 2 to 4 and the rotation CORDICs, one lane per angle.
    cord_t sin_w [4];
    cord_t cos_w [4];
    logic  flip_reg [4][N+3];

    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic signed [35:0] uw, r1, r2;
        logic               fl;
        logic [MAG_W-1:0]   mag_reg;
        logic               neg_reg, neg2_reg;
        logic [54:0]        prod_reg;
        logic [55:0]        rnd;
        logic [MAG_W-1:0]   t;
        cord_t              z0_reg, xo, yo, zo;
        logic               unused_z;

        assign uw = 36'(u_reg[l]);

        always_comb begin
            if (uw >= HALF_U) begin
                r1 = uw - TURN_U;
            end else if (uw < -HALF_U) begin
                r1 = uw + TURN_U;
            end else begin
                r1 = uw;
            end
            if (r1 > QUARTER_U) begin
                r2 = HALF_U - r1;
                fl = 1'b1;
            end else if (r1 < -QUARTER_U) begin
                r2 = -HALF_U - r1;
                fl = 1'b1;
            end else begin
                r2 = r1;
                fl = 1'b0;
            end
        end

        assign rnd = 56'(prod_reg) + (56'd1 << 23);
        assign t   = rnd[24+MAG_W-1:24];

        always_ff @(posedge aclk) begin
            if (en) begin
                mag_reg  <= r2[35] ? MAG_W'(-r2) : MAG_W'(r2);
                neg_reg  <= r2[35];
                flip_reg[l][0] <= fl;
                for (int k = 1; k < N + 3; k++) begin
                    flip_reg[l][k] <= flip_reg[l][k-1];
                end
                prod_reg <= 55'(mag_reg) * 55'(RAD_SCALE);
                neg2_reg <= neg_reg;
                z0_reg   <= neg2_reg ? -CW'(t) : CW'(t);
            end
        end

        tsdc_cordic #(.STAGES(N), .VECTORING(1'b0)) u_rot (
            .aclk  (aclk),
            .en    (en),
            .x_in  (INV_GAIN),
            .y_in  ('0),
            .z_in  (z0_reg),
            .x_out (xo),
            .y_out (yo),
            .z_out (zo)
        );

        assign sin_w[l] = yo;
        assign cos_w[l] = flip_reg[l][N+2] ? -xo : xo;
        assign unused_z = ^zo;
    end

    // Haversine term a in Q30.
    logic signed [31:0] s_lat, s_lon, c_1, c_2;
    assign s_lat = 32'(sin_w[0]);
    assign s_lon = 32'(sin_w[1]);
    assign c_1   = 32'(cos_w[2]);
    assign c_2   = 32'(cos_w[3]);

    logic signed [63:0] p_lat_reg, p_lon_reg, p_cc_reg, p_m_reg;
    logic signed [33:0] t1_reg, t1b_reg;
    logic signed [31:0] cc_reg, sq_reg;
    logic [SQ_W-1:0]    a_reg;
    logic signed [34:0] a_sum;

    assign a_sum = 35'(t1b_reg) + 35'(p_m_reg >>> 30);

    always_ff @(posedge aclk) begin
        if (en) begin
            p_lat_reg <= 64'(s_lat) * 64'(s_lat);
            p_lon_reg <= 64'(s_lon) * 64'(s_lon);
            p_cc_reg  <= 64'(c_1) * 64'(c_2);
            t1_reg    <= 34'(p_lat_reg >>> 30);
            cc_reg    <= 32'(p_cc_reg >>> 30);
            sq_reg    <= 32'(p_lon_reg >>> 30);
            p_m_reg   <= 64'(cc_reg) * 64'(sq_reg);
            t1b_reg   <= t1_reg;
            if (a_sum < 0) begin
                a_reg <= '0;
            end else if (a_sum > 35'(Q30_ONE)) begin
                a_reg <= Q30_ONE;
            end else begin
                a_reg <= SQ_W'(a_sum);
            end
        end
    end

    // Square roots of a and 1 - a.
    logic [SQ_W-1:0] ys_w, xs_w;
    logic [SQ_W-1:0] one_minus_a;
    assign one_minus_a = Q30_ONE - a_reg;

    tsdc_isqrt u_sqrt_a (
        .aclk     (aclk),
        .en       (en),
        .v_in     (RAD_W'(a_reg) << 30),
        .root_out (ys_w)
    );

    tsdc_isqrt u_sqrt_b (
        .aclk     (aclk),
        .en       (en),
        .v_in     (RAD_W'(one_minus_a) << 30),
        .root_out (xs_w)
    );

    // Central angle by vectoring.
    logic  yz_reg [N];
    cord_t vx, vy, vz;

    always_ff @(posedge aclk) begin
        if (en) begin
            yz_reg[0] <= (ys_w == '0);
            for (int k = 1; k < N; k++) begin
                yz_reg[k] <= yz_reg[k-1];
            end
        end
    end

    tsdc_cordic #(.STAGES(N), .VECTORING(1'b1)) u_vec (
        .aclk  (aclk),
        .en    (en),
        .x_in  (CW'(xs_w)),
        .y_in  (CW'(ys_w)),
        .z_in  ('0),
        .x_out (vx),
        .y_out (vy),
        .z_out (vz)
    );

    // Scaling to metres, threshold and colour.
    logic [53:0]       dprod_reg;
    logic [54:0]       drnd;
    logic [25:0]       dfull;
    logic [DIST_W-1:0] d_reg;
    logic [DIST_W-1:0] dist_out_reg;
    logic              drawn_out_reg;
    colour_t           col_out_reg;
    colour_t           col_next;
    logic              drawn_next;
    logic [MAG_W-1:0]  zpos;

    assign zpos  = (yz_reg[N-1] || vz < 0) ? '0 : MAG_W'(vz);
    assign drnd  = 55'(dprod_reg) + (55'd1 << 28);
    assign dfull = drnd[54:29];

    assign drawn_next = hp_reg[LAT-2] && (d_reg <= max_dist_reg);

    always_comb begin
        priority if (!drawn_next) begin
            col_next = COL_NONE;
        end else if (!color_mode_reg) begin
            col_next = COL_WHITE;
        end else if (d_reg <= BAND_0) begin
            col_next = COL_BAND_0;
        end else if (d_reg <= BAND_1) begin
            col_next = COL_BAND_1;
        end else if (d_reg <= BAND_2) begin
            col_next = COL_BAND_2;
        end else if (d_reg <= BAND_3) begin
            col_next = COL_BAND_3;
        end else if (d_reg <= BAND_4) begin
            col_next = COL_BAND_4;
        end else begin
            col_next = COL_FAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dprod_reg     <= 54'(zpos) * 54'(RADIUS_M);
            d_reg         <= (dfull > 26'(DIST_CAP)) ? DIST_CAP : dfull[DIST_W-1:0];
            dist_out_reg  <= hp_reg[LAT-2] ? d_reg : '0;
            drawn_out_reg <= drawn_next;
            col_out_reg   <= col_next;
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = {6'd0, col_out_reg.alpha, col_out_reg.blue, col_out_reg.green,
                       col_out_reg.red, drawn_out_reg, dist_out_reg};

    logic unused_ok;
    assign unused_ok = ^{vx, vy, s_tdata[63], hp_reg[LAT-1], paddr[1:0],
                         sin_w[2], sin_w[3], cos_w[0], cos_w[1]};

endmodule
